/* hdl/cfsr_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// cfsr_pkg: shared constants and types
// Widths, code range and the item type that goes from the front end to the
// back end of the character frequency report.
// ----------------------------------------------------------------------------
package cfsr_pkg;

    localparam int FIRST_CODE  = 32;
    localparam int CODE_END    = 128;
    localparam int MAX_LINE    = 1024;

    localparam int BYTE_W      = 8;
    localparam int CODE_W      = 7;
    localparam int COUNT_W     = 11;
    localparam int KEY_W       = COUNT_W + CODE_W;

    localparam int BIN_COUNT   = CODE_END - FIRST_CODE;
    localparam int BIN_IDX_W   = $clog2(BIN_COUNT);

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    // What the back end does with an item
    typedef enum logic [1:0] {
        OP_TALLY,   // printable byte: add one to its bin
        OP_SKIP,    // other byte: no bin, but the report restarts
        OP_FETCH    // return the next sorted entry
    } op_t;

    typedef struct packed {
        op_t                  op;
        logic [BIN_IDX_W-1:0] bin;
    } work_item_t;

endpackage : cfsr_pkg
`default_nettype wire

/* hdl/cfsr_front.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// cfsr_front: input side
// Accepts items and sorts them into tally, skip and fetch work for the queue.
// ----------------------------------------------------------------------------
module cfsr_front
    import cfsr_pkg::*;
(
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire logic              command,
    input  wire logic [BYTE_W-1:0] byte_value,
    input  wire logic              q_full,
    output logic                   q_push,
    output work_item_t             q_item
);

    logic in_range;

    assign in_range = ({1'b0, byte_value} >= (BYTE_W+1)'(FIRST_CODE)) &&
                      ({1'b0, byte_value} <  (BYTE_W+1)'(CODE_END));

    assign in_stall = q_full;
    assign q_push   = in_valid && !q_full;

    always_comb
    begin
        q_item.bin = BIN_IDX_W'(byte_value - BYTE_W'(FIRST_CODE));
        if (command)
        begin
            q_item.op = OP_FETCH;
        end
        else if (in_range)
        begin
            q_item.op = OP_TALLY;
        end
        else
        begin
            q_item.op = OP_SKIP;
        end
    end

endmodule : cfsr_front
`default_nettype wire

/* hdl/cfsr_queue.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// cfsr_queue: work queue
// Short FIFO between front and back end so that each side stalls on its own.
// ----------------------------------------------------------------------------
module cfsr_queue
    import cfsr_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       push,
    input  wire work_item_t push_item,
    output logic            full,
    input  wire logic       pop,
    output logic            head_valid,
    output work_item_t      head_item
);

    work_item_t          entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W:0]     fill_reg, fill_next;
    logic                do_push, do_pop;

    assign full       = (fill_reg == (QPTR_W+1)'(QUEUE_DEPTH));
    assign head_valid = (fill_reg != '0);
    assign head_item  = entry_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH-1)) ? '0
                                                                 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH-1)) ? '0
                                                                 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule : cfsr_queue
`default_nettype wire

/* hdl/cfsr_back.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// cfsr_back: histogram and report engine
// Holds the bin memory, updates bins on tallies and scans all bins on a
// fetch for the smallest key after the last one reported.
// ----------------------------------------------------------------------------
module cfsr_back
    import cfsr_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               q_valid,
    input  wire work_item_t         q_item,
    output logic                    q_pop,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic [CODE_W-1:0]       code,
    output logic [COUNT_W-1:0]      count,
    output logic                    is_empty,
    output logic                    is_last
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TALLY_RD,
        ST_TALLY_WR,
        ST_SCAN,
        ST_SCAN_END,
        ST_FINISH
    } state_t;

    state_t                 state_reg;
    logic [BIN_IDX_W-1:0]   op_bin_reg;
    logic [BIN_IDX_W-1:0]   scan_idx_reg;
    logic                   scan_live_reg;
    logic [CODE_W-1:0]      scan_code_reg;
    logic                   started_reg;
    logic [KEY_W-1:0]       prev_key_reg;
    logic [KEY_W-1:0]       best_key_reg;
    logic                   best_found_reg;
    logic                   multi_reg;
    logic                   out_valid_reg;
    logic [CODE_W-1:0]      code_reg;
    logic [COUNT_W-1:0]     count_reg;
    logic                   is_empty_reg;
    logic                   is_last_reg;

    // bin memory; an entry whose valid bit is clear reads as zero
    logic [COUNT_W-1:0]     bin_mem [BIN_COUNT];
    logic [BIN_COUNT-1:0]   bin_valid_reg;
    logic [COUNT_W-1:0]     rd_data_reg;
    logic                   rd_valid_reg;

    logic [BIN_IDX_W-1:0]   rd_addr;
    logic                   wr_en;
    logic [COUNT_W-1:0]     cur_cnt;
    logic [COUNT_W-1:0]     cand_cnt;
    logic [KEY_W-1:0]       cand_key;
    logic                   cand_ok;
    logic                   out_free;
    logic                   finish_go;
    logic                   fin_last;
    logic                   clear_bins;

    assign rd_addr  = (state_reg == ST_SCAN) ? scan_idx_reg : op_bin_reg;
    assign cur_cnt  = rd_valid_reg ? rd_data_reg : '0;
    assign wr_en    = (state_reg == ST_TALLY_WR) && (cur_cnt < COUNT_W'(MAX_LINE));

    // key order: smaller count first, then larger code first
    assign cand_cnt = cur_cnt;
    assign cand_key = {cand_cnt, ~scan_code_reg};
    assign cand_ok  = scan_live_reg && (cand_cnt != '0) &&
                      (!started_reg || (cand_key > prev_key_reg));

    assign out_free   = !out_valid_reg || !out_stall;
    assign finish_go  = (state_reg == ST_FINISH) && out_free;
    assign fin_last   = !best_found_reg || !multi_reg;
    assign clear_bins = finish_go && fin_last;

    assign q_pop = (state_reg == ST_IDLE) && q_valid;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            bin_mem[op_bin_reg] <= cur_cnt + COUNT_W'(1);
        end
        rd_data_reg <= bin_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bin_valid_reg <= '0;
            rd_valid_reg  <= 1'b0;
        end
        else
        begin
            if (clear_bins)
            begin
                bin_valid_reg <= '0;
            end
            else if (wr_en)
            begin
                bin_valid_reg[op_bin_reg] <= 1'b1;
            end
            rd_valid_reg <= bin_valid_reg[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            op_bin_reg     <= '0;
            scan_idx_reg   <= '0;
            scan_live_reg  <= 1'b0;
            scan_code_reg  <= '0;
            started_reg    <= 1'b0;
            prev_key_reg   <= '0;
            best_key_reg   <= '0;
            best_found_reg <= 1'b0;
            multi_reg      <= 1'b0;
            out_valid_reg  <= 1'b0;
            code_reg       <= '0;
            count_reg      <= '0;
            is_empty_reg   <= 1'b0;
            is_last_reg    <= 1'b0;
        end
        else
        begin
            // read data for the scanned bin is registered and arrives in the next cycle
            scan_live_reg <= (state_reg == ST_SCAN);

            if (out_valid_reg && !out_stall && !finish_go)
            begin
                out_valid_reg <= 1'b0;
            end

            // fold one bin into the running minimum
            if (cand_ok)
            begin
                if (!best_found_reg)
                begin
                    best_key_reg   <= cand_key;
                    best_found_reg <= 1'b1;
                end
                else
                begin
                    multi_reg <= 1'b1;
                    if (cand_key < best_key_reg)
                    begin
                        best_key_reg <= cand_key;
                    end
                end
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (q_valid)
                    begin
                        op_bin_reg <= q_item.bin;
                        unique case (q_item.op)
                            OP_TALLY:
                            begin
                                started_reg  <= 1'b0;
                                prev_key_reg <= '0;
                                state_reg    <= ST_TALLY_RD;
                            end
                            OP_SKIP:
                            begin
                                started_reg  <= 1'b0;
                                prev_key_reg <= '0;
                            end
                            OP_FETCH:
                            begin
                                scan_idx_reg   <= '0;
                                best_found_reg <= 1'b0;
                                multi_reg      <= 1'b0;
                                state_reg      <= ST_SCAN;
                            end
                            default:
                            begin
                                state_reg <= ST_IDLE;
                            end
                        endcase
                    end
                end
                ST_TALLY_RD:
                begin
                    state_reg <= ST_TALLY_WR;
                end
                ST_TALLY_WR:
                begin
                    state_reg <= ST_IDLE;
                end
                ST_SCAN:
                begin
                    scan_code_reg <= CODE_W'(FIRST_CODE + int'(scan_idx_reg));
                    scan_idx_reg  <= scan_idx_reg + 1'b1;
                    if (scan_idx_reg == BIN_IDX_W'(BIN_COUNT-1))
                    begin
                        state_reg <= ST_SCAN_END;
                    end
                end
                ST_SCAN_END:
                begin
                    state_reg <= ST_FINISH;
                end
                ST_FINISH:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        state_reg     <= ST_IDLE;
                        if (!best_found_reg)
                        begin
                            code_reg     <= '0;
                            count_reg    <= '0;
                            is_empty_reg <= 1'b1;
                            is_last_reg  <= 1'b1;
                        end
                        else
                        begin
                            code_reg     <= ~best_key_reg[CODE_W-1:0];
                            count_reg    <= best_key_reg[KEY_W-1:CODE_W];
                            is_empty_reg <= 1'b0;
                            is_last_reg  <= !multi_reg;
                        end
                        if (fin_last)
                        begin
                            started_reg  <= 1'b0;
                            prev_key_reg <= '0;
                        end
                        else
                        begin
                            started_reg  <= 1'b1;
                            prev_key_reg <= best_key_reg;
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign out_valid = out_valid_reg;
    assign code      = code_reg;
    assign count     = count_reg;
    assign is_empty  = is_empty_reg;
    assign is_last   = is_last_reg;

endmodule : cfsr_back
`default_nettype wire

/* hdl/char_frequency_sorted_report.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// char_frequency_sorted_report: character histogram with sorted report
// Counts printable bytes of a line and returns the nonzero bins one per
// fetch, by ascending count, ties by descending code.
//
//   channel | handshake            | fields
//   --------+----------------------+-----------------------------------
//   in      | in_valid / in_stall  | command, byte_value
//   out     | out_valid / out_stall| code, count, is_empty, is_last
//
// A tally reads and then writes back its bin; an ignored byte only restarts
// the report; a fetch scans all 96 bins through the single read port of the
// bin memory. A two-entry queue lets the input side keep accepting while
// the back end works or a result waits on out_stall.
// Reset clears all bins at once through their valid bits.
// ----------------------------------------------------------------------------
module char_frequency_sorted_report
    import cfsr_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic               command,
    input  wire logic [BYTE_W-1:0]  byte_value,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic [CODE_W-1:0]       code,
    output logic [COUNT_W-1:0]      count,
    output logic                    is_empty,
    output logic                    is_last
);

    work_item_t push_item;
    work_item_t head_item;
    logic       q_push, q_full, q_pop, q_valid;

    cfsr_front u_front (
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .command    (command),
        .byte_value (byte_value),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_item     (push_item)
    );

    cfsr_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_item  (push_item),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head_item  (head_item)
    );

    cfsr_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (q_valid),
        .q_item     (head_item),
        .q_pop      (q_pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .code       (code),
        .count      (count),
        .is_empty   (is_empty),
        .is_last    (is_last)
    );

`ifndef ASSERT_OFF
    a_empty_is_final: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && is_empty |-> is_last && (count == '0) && (code == '0))
        else $error("empty report item is not a final zero item");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (count <= COUNT_W'(MAX_LINE)))
        else $error("reported count above line bound");

    a_entry_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !is_empty |-> (count != '0) &&
            (code >= CODE_W'(FIRST_CODE)))
        else $error("reported entry has zero count or unprintable code");

    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        q_full |-> !q_push)
        else $error("queue pushed while full");
`endif

endmodule : char_frequency_sorted_report
`default_nettype wire
